### hw/rtl/licd_pkg.sv
// ----------------------------------------------------------------------------
// licd_pkg
// Shared constants, codes and types of the change dispenser.
// ----------------------------------------------------------------------------
package licd_pkg;

    localparam int SLOTS  = 8;
    localparam int VAL_W  = 16;
    localparam int AMT_W  = 20;
    localparam int CFG_W  = 4;
    localparam int STEP_W = $clog2(SLOTS + 1);
    localparam int DCNT_W = $clog2(AMT_W);

    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_CHANGE = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] count;
    } slot_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_EMIT,
        ST_ROT,
        ST_FINAL
    } state_t;

endpackage

### hw/rtl/licd_cell.sv
// ----------------------------------------------------------------------------
// licd_cell
// One slot of the rotating slot ring: denomination and stock.
// ----------------------------------------------------------------------------
module licd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  licd_pkg::cell_ctl_t ctl,
    input  licd_pkg::slot_t     wr_data,
    input  licd_pkg::slot_t     nbr,
    output licd_pkg::slot_t     slot
);
    import licd_pkg::*;

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] count_reg;

    // denomination has no reset value
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            value_reg <= wr_data.value;
        end
        else if (ctl.shift)
        begin
            value_reg <= nbr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.wr)
        begin
            count_reg <= wr_data.count;
        end
        else if (ctl.shift)
        begin
            count_reg <= nbr.count;
        end
    end

    assign slot.value = value_reg;
    assign slot.count = count_reg;

endmodule

### hw/rtl/licd_div.sv
// ----------------------------------------------------------------------------
// licd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module licd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [licd_pkg::AMT_W-1:0]  dividend,
    input  logic [licd_pkg::VAL_W-1:0]  divisor,
    output logic                        done,
    output logic [licd_pkg::AMT_W-1:0]  quotient
);
    import licd_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [AMT_W-1:0]  quot_reg;
    logic [AMT_W-1:0]  quot_next;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  rem_next;
    logic [VAL_W-1:0]  dvs_reg;
    logic [VAL_W-1:0]  dvs_next;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    diff;
    logic              ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[AMT_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            quot_next = {quot_reg[AMT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(AMT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### hw/rtl/limited_inventory_change_dispenser_unit.sv
// ----------------------------------------------------------------------------
// limited_inventory_change_dispenser_unit
// Greedy change dispenser over a table of slots with limited stock.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates once per change request, so
// slot 0 is always at the head when the block is idle and a load item writes
// its slot directly. A request visits every slot at the head. A slot that
// does not pay goes through check and rotate. A paying slot goes through
// check, a wait on the serial divider, multiply, stock update, line output
// and rotate; the line output waits until the output register is free.
// Only one item is in work at a time; the final result may wait in the output
// register while the next item is taken. slots_in_use is written through the
// cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module limited_inventory_change_dispenser_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [licd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [2:0]                  slot_index,
    input  logic [licd_pkg::VAL_W-1:0]  load_value,
    input  logic [licd_pkg::VAL_W-1:0]  load_count,
    input  logic [licd_pkg::AMT_W-1:0]  amount,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [licd_pkg::VAL_W-1:0]  coin_value,
    output logic [licd_pkg::VAL_W-1:0]  quantity,
    output logic [licd_pkg::AMT_W-1:0]  remaining,
    output logic                        last
);
    import licd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CFG_W-1:0]  slots_in_use_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic [AMT_W-1:0]  amt_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] used_reg;
    logic [STEP_W-1:0] used_next;
    logic [VAL_W-1:0]  q_reg;
    logic [VAL_W-1:0]  q_next;
    logic [2*VAL_W-1:0] prod_reg;
    logic [2*VAL_W-1:0] prod_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        kind_reg;
    logic [1:0]        kind_next;
    logic [VAL_W-1:0]  coin_reg;
    logic [VAL_W-1:0]  coin_next;
    logic [VAL_W-1:0]  qty_reg;
    logic [VAL_W-1:0]  qty_next;
    logic [AMT_W-1:0]  rem_reg;
    logic [AMT_W-1:0]  rem_next;
    logic              last_reg;
    logic              last_next;

    slot_t             cell_q   [SLOTS];
    cell_ctl_t         cell_ctl [SLOTS];
    slot_t             wr_data;
    slot_t             head;
    logic              rotate;
    logic              head_wr;
    logic              load_wr;
    logic              fits;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [AMT_W-1:0]  div_quot;

    assign head      = cell_q[0];
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            always_comb
            begin
                cell_ctl[gi].shift = rotate;
                cell_ctl[gi].wr    = (load_wr && (32'(slot_index) == gi))
                                     || (head_wr && (gi == 0));
            end

            licd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl[gi]),
                .wr_data (wr_data),
                .nbr     (cell_q[(gi + 1) % SLOTS]),
                .slot    (cell_q[gi])
            );
        end
    endgenerate

    licd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (amt_reg),
        .divisor  (head.value),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        fits = (step_reg < used_reg) && (amt_reg != '0) && (head.value != '0)
               && (amt_reg >= {{(AMT_W-VAL_W){1'b0}}, head.value})
               && (head.count != '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        amt_next       = amt_reg;
        step_next      = step_reg;
        used_next      = used_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        coin_next      = coin_reg;
        qty_next       = qty_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        rotate         = 1'b0;
        head_wr        = 1'b0;
        load_wr        = 1'b0;
        div_start      = 1'b0;
        wr_data.value  = load_value;
        wr_data.count  = load_count;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACT_LOAD)
                    begin
                        load_wr = 1'b1;
                    end
                    else
                    begin
                        amt_next  = amount;
                        step_next = '0;
                        if (int'(slots_in_use_reg) > SLOTS)
                        begin
                            used_next = STEP_W'(SLOTS);
                        end
                        else
                        begin
                            used_next = STEP_W'(slots_in_use_reg);
                        end
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (step_reg == STEP_W'(SLOTS))
                begin
                    state_next = ST_FINAL;
                end
                else if (fits)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_ROT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot > {{(AMT_W-VAL_W){1'b0}}, head.count})
                    begin
                        q_next = head.count;
                    end
                    else
                    begin
                        q_next = div_quot[VAL_W-1:0];
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = q_reg * head.value;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // product never exceeds the amount
                amt_next      = amt_reg - prod_reg[AMT_W-1:0];
                head_wr       = 1'b1;
                wr_data.value = head.value;
                wr_data.count = head.count - q_reg;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_LINE;
                    coin_next      = head.value;
                    qty_next       = q_reg;
                    rem_next       = amt_reg;
                    last_next      = 1'b0;
                    state_next     = ST_ROT;
                end
            end
            ST_ROT:
            begin
                rotate     = 1'b1;
                step_next  = step_reg + 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = (amt_reg == '0) ? KIND_EXACT : KIND_SHORT;
                    coin_next      = '0;
                    qty_next       = '0;
                    rem_next       = amt_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slots_in_use_reg <= '0;
            step_reg         <= '0;
            used_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                slots_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg  <= amt_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        kind_reg <= kind_next;
        coin_reg <= coin_next;
        qty_reg  <= qty_next;
        rem_reg  <= rem_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign coin_value = coin_reg;
    assign quantity   = qty_reg;
    assign remaining  = rem_reg;
    assign last       = last_reg;

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_LINE) |-> (quantity != '0) && (coin_value != '0))
        else $error("dispensed line with zero coin or quantity");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind != KIND_LINE)))
        else $error("last flag does not match result kind");

    a_exact_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EXACT) |-> (remaining == '0))
        else $error("exact result with nonzero remainder");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL) |-> (step_reg == STEP_W'(SLOTS)))
        else $error("slot ring not back at home position at end of request");

endmodule
